>>> rtl/per_id_offcpu_time_accumulator_defines.svh
// Assertion macros shared by the off-cpu time accumulator RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PER_ID_OFFCPU_TIME_ACCUMULATOR_DEFINES_SVH
`define PER_ID_OFFCPU_TIME_ACCUMULATOR_DEFINES_SVH

// General property check.
`define OCPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define OCPU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/ocpu_pkg.sv
`timescale 1ns / 1ps

package ocpu_pkg;

  // Field widths.
  localparam int unsigned ID_W      = 12;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned DELTA_W   = 40;
  localparam int unsigned STATE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // Command codes.
  localparam logic CMD_SWITCH = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUNTARY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORED_ID   = 2'd2;

  // Configuration reset values.
  localparam logic [DELTA_W-1:0] RST_STALE_LIMIT = 40'd30000000000;
  localparam logic [STATE_W-1:0] RST_VOLUNTARY   = 8'd1;
  localparam logic [ID_W-1:0]    RST_IGNORED_ID  = 12'd1;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_ns;
    logic [ID_W-1:0]   prev_id;
    logic [STATE_W-1:0] leave_state;
    logic [ID_W-1:0]   next_id;
    logic [ID_W-1:0]   query_id;
  } in_t;

  typedef struct packed {
    logic               counted;
    logic [DELTA_W-1:0] delta_ns;
    logic [TIME_W-1:0]  accum_ns;
    logic [CNT_W-1:0]   event_count;
  } out_t;

  typedef struct packed {
    logic [DELTA_W-1:0] stale_limit_ns;
    logic [STATE_W-1:0] voluntary_state;
    logic [ID_W-1:0]    highest_ignored_id;
  } cfg_t;

endpackage

>>> rtl/per_id_offcpu_time_accumulator.sv
`timescale 1ns / 1ps
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+---------------------------------
// in       | in_valid_i / in_ready_o        | in_i  (ocpu_pkg::in_t)
// out      | out_valid_o / out_ready_i      | out_o (ocpu_pkg::out_t)
// cfg      | cfg_we_i (no wait)             | cfg_idx_i, cfg_wdata_i
//
// Each transaction is accepted with its memory reads issued, then goes through
// the delta and stale compare, then write-back, as the RAM read ports are registered.
// After reset a clearing pass zeroes every entry of both tables, and no
// transaction is accepted until it ends.
// Write-back stalls only while the output register holds an unaccepted
// result; the next transaction is accepted while that result waits.

`include "per_id_offcpu_time_accumulator_defines.svh"

module per_id_offcpu_time_accumulator #(
  parameter int unsigned ID_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ocpu_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ocpu_pkg::out_t                  out_o,
  input  logic                            cfg_we_i,
  input  logic [ocpu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ocpu_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned TimeW = ocpu_pkg::TIME_W;
  localparam int unsigned CntW  = ocpu_pkg::CNT_W;
  localparam int unsigned DeltaW = ocpu_pkg::DELTA_W;
  localparam int unsigned AccW  = TimeW + CntW;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  ocpu_pkg::cfg_t cfg;

  logic [1:0]         state_q, state_d;
  logic [ID_BITS-1:0] clr_cnt_q, clr_cnt_d;
  ocpu_pkg::in_t      item_q;
  logic               fwd_q, trk_q, hit_q, clr_q;
  logic [DeltaW-1:0]  delta_q;
  logic               out_valid_q;
  ocpu_pkg::out_t     out_q;

  logic               in_fire, wb_fire;
  logic               prev_wr;
  logic [ID_BITS-1:0] prev_slot, next_slot, query_slot, item_next_slot;

  logic               start_we, start_re;
  logic [ID_BITS-1:0] start_waddr, start_raddr;
  logic [TimeW-1:0]   start_wdata, start_rdata;
  logic               acc_we, acc_re;
  logic [ID_BITS-1:0] acc_waddr, acc_raddr;
  logic [AccW-1:0]    acc_wdata, acc_rdata;

  logic [TimeW-1:0]   start_val, delta_full;
  logic               has_start, hit_d;
  logic [TimeW-1:0]   acc_total, new_total;
  logic [CntW-1:0]    acc_cnt, new_cnt;

  ocpu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Handshakes.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wb_fire    = (state_q == ST_WB) && (!out_valid_q || out_ready_i);

  // Table slots; the ignore test uses the full id.
  assign prev_slot      = ID_BITS'(in_i.prev_id);
  assign next_slot      = ID_BITS'(in_i.next_id);
  assign query_slot     = ID_BITS'(in_i.query_id);
  assign item_next_slot = ID_BITS'(item_q.next_id);
  assign prev_wr = (in_i.command == ocpu_pkg::CMD_SWITCH) &&
                   (in_i.prev_id > cfg.highest_ignored_id) &&
                   (in_i.leave_state != cfg.voluntary_state);

  // Start memory port control: clear sweep, outgoing start, then clear on use.
  always_comb begin
    start_we    = 1'b0;
    start_waddr = item_next_slot;
    start_wdata = '0;
    if (state_q == ST_INIT) begin
      start_we    = 1'b1;
      start_waddr = clr_cnt_q;
    end else if (in_fire) begin
      start_we    = prev_wr;
      start_waddr = prev_slot;
      start_wdata = in_i.now_ns;
    end else if (wb_fire) begin
      start_we    = clr_q;
    end
  end

  assign start_re    = in_fire;
  assign start_raddr = next_slot;

  ocpu_ram #(
    .DATA_W (TimeW),
    .ADDR_W (ID_BITS)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (start_we),
    .waddr_i (start_waddr),
    .wdata_i (start_wdata),
    .re_i    (start_re),
    .raddr_i (start_raddr),
    .rdata_o (start_rdata)
  );

  // Delta and stale check; the outgoing write is forwarded on equal slots.
  always_comb begin
    start_val  = fwd_q ? item_q.now_ns : start_rdata;
    has_start  = trk_q && (start_val != '0);
    delta_full = item_q.now_ns - start_val;
    hit_d      = has_start &&
                 (delta_full < {{(TimeW-DeltaW){1'b0}}, cfg.stale_limit_ns});
  end

  // Accumulator update.
  assign acc_total = acc_rdata[AccW-1 -: TimeW];
  assign acc_cnt   = acc_rdata[CntW-1:0];
  assign new_total = acc_total + {{(TimeW-DeltaW){1'b0}}, delta_q};
  assign new_cnt   = acc_cnt + CntW'(1);

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = item_next_slot;
    acc_wdata = {new_total, new_cnt};
    if (state_q == ST_INIT) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt_q;
      acc_wdata = '0;
    end else if (wb_fire) begin
      acc_we    = hit_q;
    end
  end

  assign acc_re    = in_fire;
  assign acc_raddr = (in_i.command == ocpu_pkg::CMD_READ) ? query_slot : next_slot;

  ocpu_ram #(
    .DATA_W (AccW),
    .ADDR_W (ID_BITS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_INIT: begin
        clr_cnt_d = clr_cnt_q + ID_BITS'(1);
        if (clr_cnt_q == {ID_BITS{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        if (wb_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i;
      fwd_q  <= prev_wr && (prev_slot == next_slot);
      trk_q  <= (in_i.command == ocpu_pkg::CMD_SWITCH) &&
                (in_i.next_id > cfg.highest_ignored_id);
    end
    if (state_q == ST_CALC) begin
      hit_q   <= hit_d;
      clr_q   <= has_start;
      delta_q <= delta_full[DeltaW-1:0];
    end
    if (wb_fire) begin
      out_q.counted     <= hit_q;
      out_q.delta_ns    <= hit_q ? delta_q : '0;
      out_q.accum_ns    <= hit_q ? new_total : acc_total;
      out_q.event_count <= hit_q ? new_cnt : acc_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `OCPU_ASSERT(a_accept_to_calc, in_fire |=> (state_q == ST_CALC), "accept did not start calc")
  `OCPU_ASSERT(a_wb_loads_out, wb_fire |=> out_valid_q, "write-back lost its result")
  `OCPU_ASSERT(a_acc_we_hit, (acc_we && (state_q != ST_INIT)) |-> hit_q, "acc write without hit")
  `OCPU_ASSERT_NEVER(a_read_writes_start, in_fire && start_we && in_i.command, "read wrote a start")

endmodule

>>> rtl/ocpu_ram.sv
`timescale 1ns / 1ps

// Simple dual-port synchronous RAM: one write port, one registered read port.
module ocpu_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port returns the old contents on a same-cycle collision.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ocpu_cfg.sv
`timescale 1ns / 1ps

// Configuration registers with a plain write port.
module ocpu_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [ocpu_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [ocpu_pkg::CFG_DATA_W-1:0]     wdata_i,
  output ocpu_pkg::cfg_t                      cfg_o
);

  ocpu_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        ocpu_pkg::CFG_STALE_LIMIT: begin
          cfg_d.stale_limit_ns = wdata_i[ocpu_pkg::DELTA_W-1:0];
        end
        ocpu_pkg::CFG_VOLUNTARY: begin
          cfg_d.voluntary_state = wdata_i[ocpu_pkg::STATE_W-1:0];
        end
        ocpu_pkg::CFG_IGNORED_ID: begin
          cfg_d.highest_ignored_id = wdata_i[ocpu_pkg::ID_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit_ns     <= ocpu_pkg::RST_STALE_LIMIT;
      cfg_q.voluntary_state    <= ocpu_pkg::RST_VOLUNTARY;
      cfg_q.highest_ignored_id <= ocpu_pkg::RST_IGNORED_ID;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> tb/tb_per_id_offcpu_time_accumulator.sv
`timescale 1ns / 1ps

module tb_per_id_offcpu_time_accumulator;

  localparam int unsigned ID_W       = ocpu_pkg::ID_W;
  localparam int unsigned TIME_W     = ocpu_pkg::TIME_W;
  localparam int unsigned CNT_W      = ocpu_pkg::CNT_W;
  localparam int unsigned DELTA_W    = ocpu_pkg::DELTA_W;
  localparam int unsigned STATE_W    = ocpu_pkg::STATE_W;
  localparam int unsigned CFG_IDX_W  = ocpu_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = ocpu_pkg::CFG_DATA_W;

  localparam int unsigned ID_SPAN     = 2 ** ID_W;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  ocpu_pkg::in_t         in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  ocpu_pkg::out_t        out_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow copy of the configuration and of the per-id tables.
  logic [DELTA_W-1:0] stale_lim;
  logic [STATE_W-1:0] vol_state;
  logic [ID_W-1:0]    ign_id;
  logic [TIME_W-1:0]  start_tbl [ID_SPAN];
  logic [TIME_W-1:0]  total_tbl [ID_SPAN];
  logic [CNT_W-1:0]   hits_tbl  [ID_SPAN];

  ocpu_pkg::out_t expected_q [$];

  logic [TIME_W-1:0] sim_now;
  bit                idle_on;
  int unsigned       hold_cycles;
  int unsigned       fail_cnt;
  int unsigned       switches_sent;
  int unsigned       reads_sent;
  int unsigned       deltas_seen;
  int unsigned       cycle_cnt;

  per_id_offcpu_time_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Free-running 20 ns clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one transaction to the shadow tables and returns the result it must produce.
  function automatic ocpu_pkg::out_t predict_offcpu(ocpu_pkg::in_t item);
    ocpu_pkg::out_t    res;
    logic [TIME_W-1:0] elapsed;
    logic [ID_W-1:0]   slot;
    res = '0;
    if (item.command == ocpu_pkg::CMD_READ) begin
      slot = item.query_id;
    end else begin
      // The outgoing id is recorded before the incoming id is looked up.
      if (item.prev_id > ign_id && item.leave_state != vol_state) begin
        start_tbl[item.prev_id] = item.now_ns;
      end
      slot = item.next_id;
      if (item.next_id > ign_id && start_tbl[slot] != '0) begin
        elapsed = item.now_ns - start_tbl[slot];
        if (elapsed < TIME_W'(stale_lim)) begin
          total_tbl[slot] = total_tbl[slot] + elapsed;
          hits_tbl[slot]  = hits_tbl[slot] + 1'b1;
          res.counted     = 1'b1;
          res.delta_ns    = elapsed[DELTA_W-1:0];
        end
        start_tbl[slot] = '0;
      end
    end
    res.accum_ns    = total_tbl[slot];
    res.event_count = hits_tbl[slot];
    return res;
  endfunction

  function automatic ocpu_pkg::in_t make_switch(logic [TIME_W-1:0] now,
                                                logic [ID_W-1:0] prev,
                                                logic [STATE_W-1:0] st,
                                                logic [ID_W-1:0] nxt);
    ocpu_pkg::in_t item;
    item.command     = ocpu_pkg::CMD_SWITCH;
    item.now_ns      = now;
    item.prev_id     = prev;
    item.leave_state = st;
    item.next_id     = nxt;
    item.query_id    = ID_W'($urandom);
    return item;
  endfunction

  // A read carries random junk in the fields that it does not use.
  function automatic ocpu_pkg::in_t make_read(logic [ID_W-1:0] qid);
    ocpu_pkg::in_t item;
    item.command     = ocpu_pkg::CMD_READ;
    item.now_ns      = {$urandom, $urandom};
    item.prev_id     = ID_W'($urandom);
    item.leave_state = STATE_W'($urandom);
    item.next_id     = ID_W'($urandom);
    item.query_id    = qid;
    return item;
  endfunction

  // Mostly coherent switch sequences over a small set of tracked ids, with some
  // reads, clock jumps, time running backwards and fully random noise.
  function automatic ocpu_pkg::in_t next_random_item();
    ocpu_pkg::in_t item;
    int unsigned base;
    int unsigned kind;
    int unsigned jump;
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] nxt;
    logic [STATE_W-1:0] st;
    base = (ign_id > ID_SPAN - 17) ? ID_SPAN - 16 : ign_id + 1;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      item = make_read(ID_W'($urandom));
      item.command = 1'($urandom);
    end else if (kind <= 2) begin
      item = make_read((kind == 1) ? ID_W'(base + $urandom_range(0, 15)) : ID_W'($urandom));
    end else begin
      jump = $urandom_range(0, 31);
      if (jump == 0) begin
        sim_now = sim_now - TIME_W'($urandom_range(1, 5000));
      end else if (jump == 1) begin
        sim_now = sim_now + (TIME_W'($urandom) << $urandom_range(0, 12));
      end else begin
        sim_now = sim_now + TIME_W'($urandom_range(1, 4000));
      end
      prev = ID_W'(base + $urandom_range(0, 15));
      nxt  = ID_W'(base + $urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        nxt = prev;
      end
      if ($urandom_range(0, 15) == 0) begin
        prev = ID_W'($urandom);
      end
      st = ($urandom_range(0, 3) == 0) ? vol_state : STATE_W'($urandom);
      item = make_switch(sim_now, prev, st, nxt);
    end
    return item;
  endfunction

  // Offers one transaction and waits until it is accepted. Called at a falling edge.
  task automatic send_item(input ocpu_pkg::in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i       = item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_offcpu(item));
    if (item.command == ocpu_pkg::CMD_READ) begin
      reads_sent++;
    end else begin
      switches_sent++;
    end
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every result has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ocpu_pkg::CFG_STALE_LIMIT: stale_lim = val[DELTA_W-1:0];
      ocpu_pkg::CFG_VOLUNTARY:   vol_state = val[STATE_W-1:0];
      ocpu_pkg::CFG_IGNORED_ID:  ign_id    = val[ID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(next_random_item());
  endtask

  // A switch-out followed later by a switch-in, then a read of the accumulated totals.
  task automatic test_basic_switch();
    send_item(make_switch(64'd1000, 12'd100, 8'd0, 12'd200));
    send_item(make_switch(64'd1500, 12'd200, ocpu_pkg::RST_VOLUNTARY, 12'd100));
    send_item(make_read(12'd100));
    drain();
  endtask

  task automatic test_special_cases();
    ocpu_pkg::in_t item;
    // Same id leaving and entering counts a zero delta.
    send_item(make_switch(64'd2000, 12'd300, 8'h80, 12'd300));
    // Ignored ids are neither recorded nor counted.
    send_item(make_switch(64'd2100, 12'd1, 8'd0, 12'd0));
    send_item(make_switch(64'd2200, 12'd0, 8'd0, 12'd1));
    // A start taken at time zero reads back as no start.
    send_item(make_switch(64'd0, 12'd400, 8'd2, 12'd500));
    send_item(make_switch(64'd50, 12'd500, ocpu_pkg::RST_VOLUNTARY, 12'd400));
    // Time running backwards wraps into a stale delta; the start is still cleared.
    send_item(make_switch(64'd10000, 12'd600, 8'd0, 12'd700));
    send_item(make_switch(64'd9000, 12'd700, ocpu_pkg::RST_VOLUNTARY, 12'd600));
    send_item(make_switch(64'd9500, 12'd700, ocpu_pkg::RST_VOLUNTARY, 12'd600));
    // Extreme field values.
    send_item(make_switch('1, '1, '1, 12'd4094));
    send_item(make_switch('1, 12'd4094, 8'd0, '1));
    item = '1;
    send_item(item);
    item = '0;
    item.command = ocpu_pkg::CMD_READ;
    send_item(item);
    drain();
  endtask

  task automatic test_config_regs();
    // A zero stale limit counts nothing but still clears the start.
    write_reg(ocpu_pkg::CFG_STALE_LIMIT, '0);
    send_item(make_switch(64'd20000, 12'd800, 8'd0, 12'd900));
    send_item(make_switch(64'd20100, 12'd900, ocpu_pkg::RST_VOLUNTARY, 12'd800));
    send_item(make_read(12'd800));
    drain();
    // Widest stale limit and the top voluntary code.
    write_reg(ocpu_pkg::CFG_STALE_LIMIT, '1);
    write_reg(ocpu_pkg::CFG_VOLUNTARY, 40'hAB_CDEF_12FF);
    send_item(make_switch(64'd30000, 12'd801, 8'd1, 12'd802));
    send_item(make_switch(64'd30000 + 64'hFF_FFFF_FFFE, 12'd802, 8'hFF, 12'd801));
    drain();
    // Every id ignored, then none but id zero.
    write_reg(ocpu_pkg::CFG_IGNORED_ID, 40'hF_0FFF);
    send_item(make_switch(64'd35000, 12'd4095, 8'd0, 12'd4095));
    drain();
    write_reg(ocpu_pkg::CFG_IGNORED_ID, '0);
    // A write to the unused index must leave every register alone.
    write_reg(CFG_NO_REG, 40'h00_0000_0005);
    send_item(make_switch(64'd40000, 12'd1, 8'd0, 12'd1));
    drain();
    write_reg(ocpu_pkg::CFG_STALE_LIMIT, CFG_DATA_W'(ocpu_pkg::RST_STALE_LIMIT));
    write_reg(ocpu_pkg::CFG_VOLUNTARY, CFG_DATA_W'(ocpu_pkg::RST_VOLUNTARY));
    write_reg(ocpu_pkg::CFG_IGNORED_ID, CFG_DATA_W'(ocpu_pkg::RST_IGNORED_ID));
  endtask

  // Random traffic under several register settings, with idling switched on and off.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned chunk;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(ocpu_pkg::CFG_STALE_LIMIT, CFG_DATA_W'($urandom_range(500, 5000)));
          write_reg(ocpu_pkg::CFG_VOLUNTARY, CFG_DATA_W'($urandom));
          write_reg(ocpu_pkg::CFG_IGNORED_ID, CFG_DATA_W'($urandom_range(0, 200)));
        end
        2: begin
          write_reg(ocpu_pkg::CFG_STALE_LIMIT, '1);
          write_reg(ocpu_pkg::CFG_VOLUNTARY, '0);
          write_reg(ocpu_pkg::CFG_IGNORED_ID, CFG_DATA_W'($urandom_range(1000, 4000)));
        end
        3: begin
          write_reg(ocpu_pkg::CFG_STALE_LIMIT, CFG_DATA_W'({$urandom, $urandom}));
          write_reg(ocpu_pkg::CFG_VOLUNTARY, CFG_DATA_W'($urandom));
          write_reg(ocpu_pkg::CFG_IGNORED_ID, '0);
        end
        default: ;
      endcase
      for (chunk = 0; chunk < 8; chunk++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        run_random(50);
      end
      idle_on = 1'b1;
      drain();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 300;
    run_random(40);
    drain();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    write_reg(ocpu_pkg::CFG_STALE_LIMIT, CFG_DATA_W'(ocpu_pkg::RST_STALE_LIMIT));
    write_reg(ocpu_pkg::CFG_IGNORED_ID, CFG_DATA_W'($urandom_range(0, 50)));
    run_random(400);
  endtask

  // Receiver: random stall bursts, plus the long hold-off when one is requested.
  initial begin
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        stall       = $urandom_range(1, 10) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    ocpu_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %p", out_o);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        deltas_seen += out_o.counted;
        if (out_o.counted !== want.counted) begin
          $error("counted mismatch: expected %0d, actual %0d", want.counted, out_o.counted);
          fail_cnt++;
        end
        if (out_o.delta_ns !== want.delta_ns) begin
          $error("delta_ns mismatch: expected %0d, actual %0d", want.delta_ns, out_o.delta_ns);
          fail_cnt++;
        end
        if (out_o.accum_ns !== want.accum_ns) begin
          $error("accum_ns mismatch: expected %0d, actual %0d", want.accum_ns, out_o.accum_ns);
          fail_cnt++;
        end
        if (out_o.event_count !== want.event_count) begin
          $error("event_count mismatch: expected %0d, actual %0d",
                 want.event_count, out_o.event_count);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_valid_i    = 1'b0;
    in_i          = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ocpu_pkg::CFG_STALE_LIMIT;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    hold_cycles   = 0;
    fail_cnt      = 0;
    switches_sent = 0;
    reads_sent    = 0;
    deltas_seen   = 0;
    sim_now       = 64'd100000;
    stale_lim     = ocpu_pkg::RST_STALE_LIMIT;
    vol_state     = ocpu_pkg::RST_VOLUNTARY;
    ign_id        = ocpu_pkg::RST_IGNORED_ID;
    for (int i = 0; i < ID_SPAN; i++) begin
      start_tbl[i] = '0;
      total_tbl[i] = '0;
      hits_tbl[i]  = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_switch();
    test_special_cases();
    test_config_regs();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Run covered %0d switch events and %0d reads; %0d switches added an off-cpu delta.",
             switches_sent, reads_sent, deltas_seen);
    $display("Register settings spanned zero and full stale limits and ignore limits 0 to 4095.");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
